// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in this cycle implies the consequent after the delay given by dly.
`define ASSERT_DELAYED(label, clk, rst, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_DELAYED(label, clk, rst, ante, dly, cons, msg)

`endif

`endif

// ===== rtl/segint_pkg.sv =====
package segint_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int KEY_BITS   = 2 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t b_x;
    coord_t b_y;
    coord_t c_x;
    coord_t c_y;
    coord_t d_x;
    coord_t d_y;
  } seg_in_t;

  typedef struct packed {
    logic intersects;
    logic collinear_case;
  } seg_out_t;

  // Sign of one orientation product: both flags low means zero.
  typedef struct packed {
    logic pos;
    logic neg;
  } orient_sign_t;

  // Flipping both sign bits turns the (x, then y) signed order into an
  // unsigned order on the concatenation.
  function automatic logic [KEY_BITS-1:0] lex_key(point_t p);
    lex_key = {~p.x[COORD_BITS-1], p.x[COORD_BITS-2:0],
               ~p.y[COORD_BITS-1], p.y[COORD_BITS-2:0]};
  endfunction

  function automatic logic lex_less(point_t p, point_t q);
    lex_less = lex_key(p) < lex_key(q);
  endfunction

endpackage

// ===== rtl/segint_orient.sv =====
// Three-stage orientation unit: differences, products, then the sign of
// (q-p) x (r-p).
module segint_orient
  import segint_pkg::*;
(
  input  logic         clk,
  input  point_t       p,
  input  point_t       q,
  input  point_t       r,
  output orient_sign_t sign
);

  diff_t ux;
  diff_t uy;
  diff_t vx;
  diff_t vy;
  prod_t left;
  prod_t right;

  always_ff @(posedge clk) begin
    ux <= $signed({q.x[COORD_BITS-1], q.x}) - $signed({p.x[COORD_BITS-1], p.x});
    uy <= $signed({q.y[COORD_BITS-1], q.y}) - $signed({p.y[COORD_BITS-1], p.y});
    vx <= $signed({r.x[COORD_BITS-1], r.x}) - $signed({p.x[COORD_BITS-1], p.x});
    vy <= $signed({r.y[COORD_BITS-1], r.y}) - $signed({p.y[COORD_BITS-1], p.y});
  end

  always_ff @(posedge clk) begin
    left  <= ux * vy;
    right <= vx * uy;
  end

  always_ff @(posedge clk) begin
    sign.pos <= left > right;
    sign.neg <= left < right;
  end

endmodule

// ===== rtl/segment_intersection_test.sv =====
// Segment intersection test.
//
// An item holds two segments, AB and CD, as signed integer endpoints on the
// item port. A transfer happens at a rising edge with start high and busy
// low. busy is held low: the datapath is a plain pipeline with no stall, so
// a new item may be offered in every cycle and the sustained rate is one
// item per clock.
//
// Each item gives exactly one result on the result port, with done high for
// that single cycle. done is written in step with the output register, and
// the result is taken at the rising edge that sees done high. The four
// stages are: coordinate differences and the lexicographic endpoint
// compares; the eight 17 by 17 bit products; the sign compares of the four
// orientation products; and the final decision, held in the output register.
// The multipliers set the depth of the second stage.
//
// The receiver cannot hold a result off, so there is no back-pressure and
// nothing is ever queued. A synchronous reset clears the valid bits of every
// stage, so no result appears for items that were in flight at reset.
`include "assert_macros.svh"

module segment_intersection_test
  import segint_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  seg_in_t  item,
  output logic     done,
  output seg_out_t result
);

  point_t pa;
  point_t pb;
  point_t pc;
  point_t pd;

  assign pa = '{x: item.a_x, y: item.a_y};
  assign pb = '{x: item.b_x, y: item.b_y};
  assign pc = '{x: item.c_x, y: item.c_y};
  assign pd = '{x: item.d_x, y: item.d_y};

  // Nothing downstream can stall, so the block never refuses a transfer.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Valid bits travel alongside the data through the pipeline.
  logic v1;
  logic v2;
  logic v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // The four orientation products, each three stages deep.
  orient_sign_t s_abc;
  orient_sign_t s_abd;
  orient_sign_t s_cda;
  orient_sign_t s_cdb;

  segint_orient u_orient_abc (.clk(clk), .p(pa), .q(pb), .r(pc), .sign(s_abc));
  segint_orient u_orient_abd (.clk(clk), .p(pa), .q(pb), .r(pd), .sign(s_abd));
  segint_orient u_orient_cda (.clk(clk), .p(pc), .q(pd), .r(pa), .sign(s_cda));
  segint_orient u_orient_cdb (.clk(clk), .p(pc), .q(pd), .r(pb), .sign(s_cdb));

  // Overlap test for the collinear case. Each segment's endpoints are put in
  // lexicographic order; the segments miss only when one segment's upper
  // end lies below the other's lower end. All compares are done on the raw
  // endpoints in parallel and the sorting becomes a selection among them.
  logic lt_ba;
  logic lt_dc;
  logic ab_below_cd;
  logic cd_below_ab;
  logic overlap_now;

  always_comb begin
    lt_ba = lex_less(pb, pa);
    lt_dc = lex_less(pd, pc);
    if (lt_ba) begin
      ab_below_cd = lt_dc ? lex_less(pa, pd) : lex_less(pa, pc);
    end else begin
      ab_below_cd = lt_dc ? lex_less(pb, pd) : lex_less(pb, pc);
    end
    if (lt_dc) begin
      cd_below_ab = lt_ba ? lex_less(pc, pb) : lex_less(pc, pa);
    end else begin
      cd_below_ab = lt_ba ? lex_less(pd, pb) : lex_less(pd, pa);
    end
    overlap_now = !(ab_below_cd || cd_below_ab);
  end

  // The overlap flag waits until the orientation signs catch up.
  logic overlap1;
  logic overlap2;
  logic overlap3;

  always_ff @(posedge clk) begin
    overlap1 <= overlap_now;
    overlap2 <= overlap1;
    overlap3 <= overlap2;
  end

  // Final decision. The product of two signs is zero when either is zero,
  // and positive only when both are non-zero and agree.
  logic     sab_zero;
  logic     scd_zero;
  logic     sab_pos;
  logic     scd_pos;
  seg_out_t result_next;

  always_comb begin
    sab_zero = !(s_abc.pos || s_abc.neg) || !(s_abd.pos || s_abd.neg);
    scd_zero = !(s_cda.pos || s_cda.neg) || !(s_cdb.pos || s_cdb.neg);
    sab_pos  = (s_abc.pos && s_abd.pos) || (s_abc.neg && s_abd.neg);
    scd_pos  = (s_cda.pos && s_cdb.pos) || (s_cda.neg && s_cdb.neg);
    result_next.collinear_case = sab_zero && scd_zero;
    if (result_next.collinear_case) begin
      result_next.intersects = overlap3;
    end else begin
      result_next.intersects = !sab_pos && !scd_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (v3) begin
      result <= result_next;
    end
  end

  // Every accepted item produces its result.
  `ASSERT_DELAYED(a_result_follows, clk, rst, accept, 4, done,
                  "accepted item did not produce a result")
  // No result appears without a matching accepted item ahead of it.
  `ASSERT_DELAYED(a_no_spurious, clk, rst, !accept, 4, !done,
                  "result produced without an item")
  // Segments that share their start point must always be reported as meeting.
  `ASSERT_DELAYED(a_shared_start, clk, rst,
                  accept && item.a_x == item.c_x && item.a_y == item.c_y, 4,
                  result.intersects,
                  "segments with a common endpoint reported as disjoint")

endmodule

// ===== tb/sv/segint_checker.sv =====
module segint_checker
  import segint_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  seg_in_t  item,
  input  logic     done,
  input  seg_out_t result,
  output int       mismatches,
  output int       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  seg_out_t expected_verdicts[$];

  // Sign of (q-p) x (r-p), worked out exactly in 64-bit integers.
  function automatic int turn_sign(point_t p, point_t q, point_t r);
    longint ux, uy, vx, vy, lhs, rhs;
    ux  = longint'(q.x) - longint'(p.x);
    uy  = longint'(q.y) - longint'(p.y);
    vx  = longint'(r.x) - longint'(p.x);
    vy  = longint'(r.y) - longint'(p.y);
    lhs = ux * vy;
    rhs = vx * uy;
    return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
  endfunction

  function automatic bit comes_first(point_t p, point_t q);
    if (p.x != q.x) return p.x < q.x;
    return p.y < q.y;
  endfunction

  function automatic seg_out_t judge_pair(seg_in_t v);
    point_t   a, b, c, d, t;
    int       sab, scd;
    seg_out_t verdict;
    a = '{x: v.a_x, y: v.a_y};
    b = '{x: v.b_x, y: v.b_y};
    c = '{x: v.c_x, y: v.c_y};
    d = '{x: v.d_x, y: v.d_y};
    sab = turn_sign(a, b, c) * turn_sign(a, b, d);
    scd = turn_sign(c, d, a) * turn_sign(c, d, b);
    verdict.collinear_case = (sab == 0) && (scd == 0);
    if (verdict.collinear_case) begin
      if (comes_first(b, a)) begin
        t = a; a = b; b = t;
      end
      if (comes_first(d, c)) begin
        t = c; c = d; d = t;
      end
      verdict.intersects = !(comes_first(b, c) || comes_first(d, a));
    end else begin
      verdict.intersects = (sab <= 0) && (scd <= 0);
    end
    return verdict;
  endfunction

  task automatic note_failure(string what, seg_out_t want, seg_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected intersects=%0b collinear_case=%0b, got %0b %0b",
               $realtime, what, want.intersects, want.collinear_case,
               got.intersects, got.collinear_case);
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    seg_out_t want;
    if (rst) begin
      expected_verdicts.delete();
    end else begin
      if (done) begin
        if (expected_verdicts.size() == 0) begin
          note_failure("result with nothing expected", '0, result);
        end else begin
          want = expected_verdicts.pop_front();
          if (result.intersects !== want.intersects)
            note_failure("intersects mismatch", want, result);
          else if (result.collinear_case !== want.collinear_case)
            note_failure("collinear_case mismatch", want, result);
        end
      end
      if (start && !busy) expected_verdicts = {expected_verdicts, judge_pair(item)};
    end
    outstanding = expected_verdicts.size();
  end

endmodule

// ===== tb/sv/tb_segment_intersection_test.sv =====
module tb_segment_intersection_test
  import segint_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  seg_in_t  item;
  logic     done;
  seg_out_t result;
  int       mismatches;
  int       outstanding;
  bit       gaps_on;

  segment_intersection_test i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  // The checker sees every transfer in both directions, predicts the verdict
  // of each accepted segment pair and compares it with what comes out.
  segint_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A millisecond is far longer than a clean run, which leaves a
  // very wide margin for the pipeline and the random gaps.
  initial begin
    #1ms;
    $display("tb_segment_intersection_test: done, errors");
    $finish;
  end

  function automatic seg_in_t make_pair(int ax, int ay, int bx, int by,
                                        int cx, int cy, int dx, int dy);
    seg_in_t v;
    v.a_x = coord_t'(ax); v.a_y = coord_t'(ay);
    v.b_x = coord_t'(bx); v.b_y = coord_t'(by);
    v.c_x = coord_t'(cx); v.c_y = coord_t'(cy);
    v.d_x = coord_t'(dx); v.d_y = coord_t'(dy);
    return v;
  endfunction

  // Offers one pair and returns just after the edge at which it was taken.
  // Gaps are only inserted before start is raised, so start is never lowered
  // and raised again within the same time step.
  task automatic offer(input seg_in_t v);
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
    item  <= v;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hand-picked pairs: plain crossings and misses, touching, every flavour of
  // collinear overlap, point-sized segments and the coordinate extremes,
  // where the cross products need their full width.
  task automatic directed_pairs();
    offer(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
    offer(make_pair(0, 0, 1, 0, 5, 5, 6, 7));
    offer(make_pair(0, 0, 10, 0, 5, 0, 5, 5));
    offer(make_pair(0, 0, 5, 5, 5, 5, 9, 1));
    offer(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
    offer(make_pair(0, 0, 3, 3, 5, 5, 9, 9));
    offer(make_pair(3, 3, 0, 0, 6, 6, 3, 3));
    offer(make_pair(2, 10, 2, 0, 2, -5, 2, -1));
    offer(make_pair(2, 10, 2, 0, 2, 20, 2, 5));
    offer(make_pair(4, 4, 4, 4, 0, 0, 8, 8));
    offer(make_pair(4, 5, 4, 5, 0, 0, 8, 8));
    offer(make_pair(7, -3, 7, -3, 7, -3, 7, -3));
    offer(make_pair(7, -3, 7, -3, 7, -2, 7, -2));
    offer(make_pair(0, 0, 10, 0, 0, 1, 10, 1));
    offer(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    offer(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    offer(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    offer(make_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0));
    offer(make_pair(-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767));
    offer(make_pair(-32768, 32767, 32767, -32768, -32767, 32767, 32767, -32767));
    offer(make_pair(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846));
    offer(make_pair(-1, 0, 0, -1, 1, 1, -1, -1));
  endtask

  function automatic coord_t any_coord();
    return coord_t'($urandom_range(0, 65535));
  endfunction

  function automatic coord_t near_origin();
    return coord_t'(int'($urandom_range(0, 16)) - 8);
  endfunction

  function automatic coord_t corner_coord();
    int corners[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    return coord_t'(corners[$urandom_range(0, 6)]);
  endfunction

  // Four points on one line through a random base point. Steps and
  // multipliers are kept small so that overlaps, touches and gaps between
  // the two segments all turn up often.
  function automatic seg_in_t on_one_line();
    int px, py, sx, sy;
    int k[4];
    px = int'($urandom_range(0, 2000)) - 1000;
    py = int'($urandom_range(0, 2000)) - 1000;
    sx = int'($urandom_range(0, 8)) - 4;
    sy = int'($urandom_range(0, 8)) - 4;
    foreach (k[i]) k[i] = int'($urandom_range(0, 40)) - 20;
    return make_pair(px + k[0] * sx, py + k[0] * sy, px + k[1] * sx, py + k[1] * sy,
                     px + k[2] * sx, py + k[2] * sy, px + k[3] * sx, py + k[3] * sy);
  endfunction

  function automatic seg_in_t random_pair();
    seg_in_t v;
    int      pick;
    pick = $urandom_range(0, 99);
    v = {any_coord(), any_coord(), any_coord(), any_coord(),
         any_coord(), any_coord(), any_coord(), any_coord()};
    if (pick < 30) begin
      // Fully random coordinates, which also toggle every input bit.
    end else if (pick < 50) begin
      v = {near_origin(), near_origin(), near_origin(), near_origin(),
           near_origin(), near_origin(), near_origin(), near_origin()};
    end else if (pick < 75) begin
      v = on_one_line();
    end else if (pick < 85) begin
      // One endpoint of CD is moved onto an endpoint of AB.
      case ($urandom_range(0, 3))
        0: begin v.c_x = v.a_x; v.c_y = v.a_y; end
        1: begin v.d_x = v.a_x; v.d_y = v.a_y; end
        2: begin v.c_x = v.b_x; v.c_y = v.b_y; end
        default: begin v.d_x = v.b_x; v.d_y = v.b_y; end
      endcase
    end else if (pick < 95) begin
      v = {corner_coord(), corner_coord(), corner_coord(), corner_coord(),
           corner_coord(), corner_coord(), corner_coord(), corner_coord()};
    end else begin
      // A point-sized segment on one side or the other.
      if ($urandom_range(0, 1)) begin
        v.b_x = v.a_x; v.b_y = v.a_y;
      end else begin
        v.d_x = v.c_x; v.d_y = v.c_y;
      end
    end
    return v;
  endfunction

  initial begin
    gaps_on = 1'b1;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_pairs();

    // The random part has a long stretch in the middle with no gaps at all,
    // so that the pipeline is kept full on every cycle for a while.
    for (int n = 0; n < 2000; n++) begin
      gaps_on = !(n >= 800 && n < 1300);
      offer(random_pair());
    end
    start <= 1'b0;

    // Wait for every outstanding verdict, then keep watching the result port so
    // that a stray result behind the last one would still be caught.
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);

    if (mismatches == 0) begin
      $display("tb_segment_intersection_test: done, clean");
    end else begin
      $display("tb_segment_intersection_test: done, errors");
    end
    $finish;
  end

endmodule
